// ----- sv/first_fit_slot_allocator_evict_defines.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_SLOT_ALLOCATOR_EVICT_DEFINES_SVH
`define FIRST_FIT_SLOT_ALLOCATOR_EVICT_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define FFSA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger in one cycle implies a consequence in the next.
`define FFSA_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ----- sv/ffsa_pkg.sv -----
`timescale 1ns / 1ps
package ffsa_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int OVF_DEPTH  = 16;
  localparam int TAG_BITS   = 8;

  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int OVF_W   = (OVF_DEPTH > 1) ? $clog2(OVF_DEPTH) : 1;
  localparam int FILL_W  = $clog2(OVF_DEPTH + 1);
  localparam int CMD_W   = 3;
  localparam int SIZE_W  = 5;
  localparam int INDEX_W = 5;
  localparam int RSLOT_W = 6;

  typedef logic [TAG_BITS-1:0] tag_t;

  localparam logic [CMD_W-1:0] CMD_PICKUP   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SWAP_IN  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd4;

  // Write requests from the sequencer into the storage.
  typedef struct packed {
    logic              map_we;
    logic [SLOT_W-1:0] map_waddr;
    tag_t              map_wdata;
    logic              ovf_we;
    logic [OVF_W-1:0]  ovf_waddr;
    tag_t              ovf_wdata;
  } store_wr_t;

endpackage

// ----- sv/ffsa_store.sv -----
`timescale 1ns / 1ps
module ffsa_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ffsa_pkg::store_wr_t       wr,
  input  logic [ffsa_pkg::SLOT_W-1:0] map_raddr,
  output ffsa_pkg::tag_t            map_rdata,
  input  logic [ffsa_pkg::OVF_W-1:0]  ovf_raddr,
  output ffsa_pkg::tag_t            ovf_rdata
);
  import ffsa_pkg::*;

  tag_t slot_map_r [SLOT_COUNT];
  tag_t ovf_list_r [OVF_DEPTH];

  // The slot map starts empty; the overflow list is only read below its fill.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_map_r[i] <= '0;
      end
    end else if (wr.map_we) begin
      slot_map_r[wr.map_waddr] <= wr.map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.ovf_we) begin
      ovf_list_r[wr.ovf_waddr] <= wr.ovf_wdata;
    end
  end

  assign map_rdata = slot_map_r[map_raddr];
  assign ovf_rdata = ovf_list_r[ovf_raddr];

endmodule

// ----- sv/first_fit_slot_allocator_evict.sv -----
`timescale 1ns / 1ps
// First-fit slot allocator with eviction to an overflow list. A command
// transaction is taken when start is high and busy is low; busy then stays
// high until the result, which appears for exactly one cycle with out_valid
// high and cannot be held off by the receiver. All work runs through one
// sequencer that reads one slot-map entry and one overflow entry per cycle
// and writes at most one of each. A pickup that fits makes a pass over the
// slot map and then writes each placed slot; each eviction adds a clear of
// that run and a fresh fit pass. Swap-in adds a search and compaction of
// the overflow list.
module first_fit_slot_allocator_evict (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ffsa_pkg::CMD_W-1:0]    in_command,
  input  ffsa_pkg::tag_t                in_tag_id,
  input  logic [ffsa_pkg::SIZE_W-1:0]   in_run_size,
  input  logic [ffsa_pkg::INDEX_W-1:0]  in_slot_index,
  output logic                          out_valid,
  output logic                          out_ok,
  output ffsa_pkg::tag_t                out_result_tag,
  output logic signed [ffsa_pkg::RSLOT_W-1:0] out_result_slot,
  output logic [ffsa_pkg::FILL_W-1:0]   out_overflow_count
);
  import ffsa_pkg::*;
  `include "first_fit_slot_allocator_evict_defines.svh"

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PREP  = 10'b0000000010,
    S_FIT   = 10'b0000000100,
    S_FILL  = 10'b0000001000,
    S_EVICT = 10'b0000010000,
    S_CLEAR = 10'b0000100000,
    S_SRCH  = 10'b0001000000,
    S_SHIFT = 10'b0010000000,
    S_FIND  = 10'b0100000000,
    S_CONT  = 10'b1000000000
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  state_t                   state_r, state_nxt;
  logic [CMD_W-1:0]         cmd_r, cmd_nxt;
  tag_t                     tag_r, tag_nxt;
  logic [SIZE_W-1:0]        size_r, size_nxt;
  logic [INDEX_W-1:0]       slot_r, slot_nxt;
  logic [SLOT_W-1:0]        idx_r, idx_nxt;
  logic [SLOT_W-1:0]        ep_r, ep_nxt;
  logic [SIZE_W:0]          run_r, run_nxt;
  logic [SIZE_W:0]          cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]        fit_r, fit_nxt;
  tag_t                     ctag_r, ctag_nxt;
  logic                     rem_r, rem_nxt;
  logic [OVF_W-1:0]         oi_r, oi_nxt;
  logic [FILL_W-1:0]        fill_r, fill_nxt;
  logic                     vld_r, vld_nxt;
  logic                     ok_r, ok_nxt;
  tag_t                     rtag_r, rtag_nxt;
  logic [RSLOT_W-1:0]       rslot_r, rslot_nxt;

  store_wr_t                wr;
  logic [SLOT_W-1:0]        map_raddr;
  tag_t                     map_rdata;
  logic [OVF_W-1:0]         ovf_raddr;
  tag_t                     ovf_rdata;
  logic [SIZE_W:0]          run_inc;
  logic [SIZE_W+1:0]        fit_calc;
  logic [FILL_W:0]          oi_next_ext;

  ffsa_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .map_raddr (map_raddr),
    .map_rdata (map_rdata),
    .ovf_raddr (ovf_raddr),
    .ovf_rdata (ovf_rdata)
  );

  // One read address per store, chosen by the sequencer state.
  always_comb begin
    case (state_r)
      S_PREP:          map_raddr = slot_r[SLOT_W-1:0];
      S_EVICT, S_CLEAR: map_raddr = ep_r;
      S_FIND:          map_raddr = idx_r - 1'b1;
      default:         map_raddr = idx_r;
    endcase
    ovf_raddr = (state_r == S_SHIFT) ? OVF_W'(oi_r + 1'b1) : oi_r;
  end

  assign run_inc     = run_r + 1'b1;
  assign fit_calc    = (SIZE_W+2)'(idx_r) + 1'b1 - (SIZE_W+2)'(size_r);
  assign oi_next_ext = (FILL_W+1)'(oi_r) + 1'b1;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    tag_nxt   = tag_r;
    size_nxt  = size_r;
    slot_nxt  = slot_r;
    idx_nxt   = idx_r;
    ep_nxt    = ep_r;
    run_nxt   = run_r;
    cnt_nxt   = cnt_r;
    fit_nxt   = fit_r;
    ctag_nxt  = ctag_r;
    rem_nxt   = rem_r;
    oi_nxt    = oi_r;
    fill_nxt  = fill_r;
    vld_nxt   = 1'b0;
    ok_nxt    = ok_r;
    rtag_nxt  = rtag_r;
    rslot_nxt = rslot_r;
    wr        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_command;
          tag_nxt   = in_tag_id;
          size_nxt  = in_run_size;
          slot_nxt  = in_slot_index;
          ok_nxt    = 1'b0;
          rtag_nxt  = '0;
          rslot_nxt = '1;
          state_nxt = S_PREP;
        end
      end

      // Checks the transaction and picks the first working state.
      S_PREP: begin
        idx_nxt = '0;
        run_nxt = '0;
        ep_nxt  = '0;
        oi_nxt  = '0;
        rem_nxt = 1'b0;
        case (cmd_r)
          CMD_PICKUP: begin
            if (tag_r == '0 || size_r == '0 ||
                (SIZE_W+1)'(size_r) > (SIZE_W+1)'(SLOT_COUNT)) begin
              vld_nxt   = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_FIT;
            end
          end
          CMD_SWAP_IN: begin
            if (fill_r == '0) begin
              vld_nxt   = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_SRCH;
            end
          end
          CMD_REMOVE, CMD_FIND: begin
            if ((INDEX_W+1)'(slot_r) >= (INDEX_W+1)'(SLOT_COUNT) || map_rdata == '0) begin
              vld_nxt   = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              ctag_nxt = map_rdata;
              if (cmd_r == CMD_REMOVE) begin
                rem_nxt   = 1'b1;
                ep_nxt    = slot_r[SLOT_W-1:0];
                state_nxt = S_CLEAR;
              end else begin
                idx_nxt   = slot_r[SLOT_W-1:0];
                state_nxt = S_FIND;
              end
            end
          end
          CMD_CONTAINS: begin
            state_nxt = S_CONT;
          end
          default: begin
            vld_nxt   = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end

      // Walks the slot map counting the current free stretch.
      S_FIT: begin
        if (map_rdata == '0) begin
          run_nxt = run_inc;
          if (run_inc >= (SIZE_W+1)'(size_r)) begin
            fit_nxt   = fit_calc[SLOT_W-1:0];
            idx_nxt   = fit_calc[SLOT_W-1:0];
            cnt_nxt   = (SIZE_W+1)'(size_r);
            state_nxt = S_FILL;
          end
        end else begin
          run_nxt = '0;
        end
        if (state_nxt == S_FIT) begin
          if (idx_r == LAST_SLOT) begin
            state_nxt = S_EVICT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_FILL: begin
        wr.map_we    = 1'b1;
        wr.map_waddr = idx_r;
        wr.map_wdata = tag_r;
        idx_nxt      = idx_r + 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == (SIZE_W+1)'(1) || idx_r == LAST_SLOT) begin
          ok_nxt    = 1'b1;
          rslot_nxt = RSLOT_W'(fit_r);
          vld_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      // Finds the next occupied run from the left and pushes its tag if the list has room.
      S_EVICT: begin
        if (map_rdata != '0) begin
          ctag_nxt = map_rdata;
          if (fill_r < FILL_W'(OVF_DEPTH)) begin
            wr.ovf_we    = 1'b1;
            wr.ovf_waddr = OVF_W'(fill_r);
            wr.ovf_wdata = map_rdata;
            fill_nxt     = fill_r + 1'b1;
          end
          state_nxt = S_CLEAR;
        end else if (ep_r == LAST_SLOT) begin
          vld_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ep_nxt = ep_r + 1'b1;
        end
      end

      // Clears the run forward from the eviction or remove pointer.
      S_CLEAR: begin
        if (map_rdata == ctag_r) begin
          wr.map_we    = 1'b1;
          wr.map_waddr = ep_r;
          wr.map_wdata = '0;
        end
        if (map_rdata != ctag_r || ep_r == LAST_SLOT) begin
          if (rem_r) begin
            ok_nxt    = 1'b1;
            rtag_nxt  = ctag_r;
            rslot_nxt = RSLOT_W'(slot_r);
            vld_nxt   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = '0;
            run_nxt   = '0;
            state_nxt = S_FIT;
          end
        end else begin
          ep_nxt = ep_r + 1'b1;
        end
      end

      S_SRCH: begin
        if (ovf_rdata == tag_r) begin
          state_nxt = S_SHIFT;
        end else if (oi_next_ext >= (FILL_W+1)'(fill_r)) begin
          vld_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          oi_nxt = oi_r + 1'b1;
        end
      end

      // Closes the gap left by the fetched tag, then runs a pickup.
      S_SHIFT: begin
        if (oi_next_ext < (FILL_W+1)'(fill_r)) begin
          wr.ovf_we    = 1'b1;
          wr.ovf_waddr = oi_r;
          wr.ovf_wdata = ovf_rdata;
          oi_nxt       = OVF_W'(oi_next_ext);
        end else begin
          fill_nxt  = fill_r - 1'b1;
          cmd_nxt   = CMD_PICKUP;
          state_nxt = S_PREP;
        end
      end

      S_FIND: begin
        if (idx_r == '0 || map_rdata != ctag_r) begin
          ok_nxt    = 1'b1;
          rslot_nxt = RSLOT_W'(idx_r);
          vld_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end

      S_CONT: begin
        if (map_rdata == tag_r) begin
          ok_nxt    = 1'b1;
          vld_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else if (idx_r == LAST_SLOT) begin
          vld_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    tag_r   <= tag_nxt;
    size_r  <= size_nxt;
    slot_r  <= slot_nxt;
    idx_r   <= idx_nxt;
    ep_r    <= ep_nxt;
    run_r   <= run_nxt;
    cnt_r   <= cnt_nxt;
    fit_r   <= fit_nxt;
    ctag_r  <= ctag_nxt;
    rem_r   <= rem_nxt;
    oi_r    <= oi_nxt;
    ok_r    <= ok_nxt;
    rtag_r  <= rtag_nxt;
    rslot_r <= rslot_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = vld_r;
  assign out_ok             = ok_r;
  assign out_result_tag     = rtag_r;
  assign out_result_slot    = rslot_r;
  assign out_overflow_count = fill_r;

  // A result is only raised as the sequencer returns to idle.
  `FFSA_ASSERT_ALWAYS(a_valid_idle, !vld_r || state_r == S_IDLE, "result outside idle")
  // The overflow list never holds more than its depth.
  `FFSA_ASSERT_ALWAYS(a_fill_bound, fill_r <= FILL_W'(OVF_DEPTH), "overflow fill too large")
  // An accepted transaction always enters the check state.
  `FFSA_ASSERT_NEXT(a_start_prep, start && !busy, state_r == S_PREP, "start not taken")
  // The fill pass never runs with nothing left to place.
  `FFSA_ASSERT_ALWAYS(a_fill_cnt, state_r != S_FILL || cnt_r != '0, "fill count empty")

endmodule
